FILE: rtl/hvn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared types and constants of the heightmap vertex normal block.
// ----------------------------------------------------------------------------
package hvn_pkg;

   localparam int CNT_W    = 11;
   localparam int HGT_W    = 16;
   localparam int POS_W    = 10;
   localparam int MAX_ROWS = 1024;
   localparam int Q_ONE    = 16384;

   localparam logic [1:0] CSR_SCALE = 2'd0;
   localparam logic [1:0] CSR_COLS  = 2'd1;
   localparam logic [1:0] CSR_ROWS  = 2'd2;

   typedef struct packed {
      logic [HGT_W-1:0] hc;
      logic [HGT_W-1:0] hl;
      logic [HGT_W-1:0] hr;
      logic [HGT_W-1:0] hu;
      logic [HGT_W-1:0] hd;
      logic [HGT_W-1:0] hur;
      logic [HGT_W-1:0] hdl;
      logic             left;
      logic             up;
      logic             right;
      logic             down;
      logic [POS_W-1:0] vc;
      logic [POS_W-1:0] vr;
      logic             last;
      logic             done;
   } job_type;

endpackage

FILE: rtl/hvn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_front
// Takes samples, keeps the line buffer and 3x3 window, and issues one job per
// vertex that the sample completes.
// ----------------------------------------------------------------------------
module hvn_front
   import hvn_pkg::*;
#(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [HGT_W-1:0] req_sample_height,
   input  logic [CNT_W-1:0] grid_columns,
   input  logic [CNT_W-1:0] grid_rows,
   input  logic             pos_clear,
   output logic             job_push,
   input  logic             job_full,
   output job_type          job_data
);

   localparam int AW = $clog2(MAX_COLUMNS);
   localparam logic [1:0] FS_IDLE  = 2'd0;
   localparam logic [1:0] FS_SHIFT = 2'd1;
   localparam logic [1:0] FS_EMIT  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   col_ff, col_in, row_ff, row_in;
   logic [CNT_W-1:0]   c_cur, r_cur, c_ff, r_ff;
   logic [HGT_W-1:0]   smp_ff;
   logic [2*HGT_W-1:0] rd_ff;
   logic [2*HGT_W-1:0] line_mem [MAX_COLUMNS];
   logic [3:0]         cand_ff, cand_in, cand_new, rem;
   logic [HGT_W-1:0]   win_ff [9];
   logic [HGT_W-1:0]   grid [4][4];
   job_type            jobs [4];
   logic [1:0]         sel;
   logic               accept, c_pos, r_pos, c_end, r_end, c_last;

   assign accept   = req_push && (state_ff == FS_IDLE);
   assign req_full = (state_ff != FS_IDLE);
   assign c_cur    = (col_ff >= grid_columns || int'(col_ff) >= MAX_COLUMNS) ? '0 : col_ff;
   assign r_cur    = (row_ff >= grid_rows) ? '0 : row_ff;

   assign c_pos  = (c_ff != '0);
   assign r_pos  = (r_ff != '0);
   assign c_end  = ({1'b0, c_ff} + (CNT_W+1)'(1)) == {1'b0, grid_columns};
   assign r_end  = ({1'b0, r_ff} + (CNT_W+1)'(1)) == {1'b0, grid_rows};
   assign c_last = ({1'b0, c_ff} + (CNT_W+1)'(1)) >= {1'b0, grid_columns};
   assign cand_new = {r_end && c_end, r_end && c_pos, c_end && r_pos, c_pos && r_pos};

   always_ff @(posedge clock) begin
      if (state_ff == FS_SHIFT) begin
         line_mem[AW'(c_ff)] <= {rd_ff[HGT_W-1:0], smp_ff};
      end
      rd_ff <= line_mem[AW'(c_cur)];
   end

   always_comb begin
      for (int rr = 0; rr < 4; rr++) begin
         for (int cc = 0; cc < 4; cc++) begin
            grid[rr][cc] = (rr < 3 && cc < 3) ? win_ff[rr*3+cc] : '0;
         end
      end
   end

   always_comb begin
      int orr;
      int occ;
      logic [CNT_W-1:0] vc;
      logic [CNT_W-1:0] vr;
      for (int k = 0; k < 4; k++) begin
         orr = 1 + (k / 2);
         occ = 1 + (k % 2);
         vc  = ((k % 2) == 1) ? c_ff : c_ff - CNT_W'(1);
         vr  = ((k / 2) == 1) ? r_ff : r_ff - CNT_W'(1);
         jobs[k].hc    = grid[orr][occ];
         jobs[k].hl    = grid[orr][occ-1];
         jobs[k].hr    = grid[orr][occ+1];
         jobs[k].hu    = grid[orr-1][occ];
         jobs[k].hd    = grid[orr+1][occ];
         jobs[k].hur   = grid[orr-1][occ+1];
         jobs[k].hdl   = grid[orr+1][occ-1];
         jobs[k].left  = (vc != '0);
         jobs[k].up    = (vr != '0);
         jobs[k].right = ({1'b0, vc} + (CNT_W+1)'(1)) < {1'b0, grid_columns};
         jobs[k].down  = ({1'b0, vr} + (CNT_W+1)'(1)) < {1'b0, grid_rows};
         jobs[k].vc    = vc[POS_W-1:0];
         jobs[k].vr    = vr[POS_W-1:0];
         jobs[k].last  = 1'b0;
         jobs[k].done  = (({1'b0, vc} + (CNT_W+1)'(1)) == {1'b0, grid_columns}) &&
                         (({1'b0, vr} + (CNT_W+1)'(1)) == {1'b0, grid_rows});
      end
   end

   always_comb begin
      priority if (cand_ff[0]) begin
         sel = 2'd0;
      end else if (cand_ff[1]) begin
         sel = 2'd1;
      end else if (cand_ff[2]) begin
         sel = 2'd2;
      end else begin
         sel = 2'd3;
      end
      rem           = cand_ff & ~(4'b0001 << sel);
      job_data      = jobs[sel];
      job_data.last = (rem == 4'b0000);
   end

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      cand_in  = cand_ff;
      job_push = 1'b0;
      unique case (state_ff)
         FS_IDLE: begin
            if (accept) begin
               state_in = FS_SHIFT;
            end
         end
         FS_SHIFT: begin
            cand_in  = cand_new;
            state_in = FS_EMIT;
            if (c_last) begin
               col_in = '0;
               row_in = (({1'b0, r_ff} + (CNT_W+1)'(1)) >= {1'b0, grid_rows}) ?
                        '0 : r_ff + CNT_W'(1);
            end else begin
               col_in = c_ff + CNT_W'(1);
               row_in = r_ff;
            end
         end
         FS_EMIT: begin
            if (cand_ff == 4'b0000) begin
               state_in = FS_IDLE;
            end else if (!job_full) begin
               job_push = 1'b1;
               cand_in  = rem;
               if (rem == 4'b0000) begin
                  state_in = FS_IDLE;
               end
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
      if (pos_clear) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         cand_ff  <= '0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         cand_ff  <= cand_in;
         if (state_ff == FS_SHIFT) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i*3]   <= win_ff[i*3+1];
               win_ff[i*3+1] <= win_ff[i*3+2];
            end
            win_ff[2] <= rd_ff[2*HGT_W-1:HGT_W];
            win_ff[5] <= rd_ff[HGT_W-1:0];
            win_ff[8] <= smp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         c_ff   <= c_cur;
         r_ff   <= r_cur;
         smp_ff <= req_sample_height;
      end
   end

`ifndef SYNTHESIS
   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      job_push && job_data.last |=> state_ff == FS_IDLE)
      else $error("front still busy after last job of a sample");
`endif

endmodule

FILE: rtl/hvn_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_queue
// Two-entry job queue between the front and the normal unit.
// ----------------------------------------------------------------------------
module hvn_queue
   import hvn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  job_type push_data,
   input  logic    pop,
   output logic    empty,
   output job_type pop_data
);

   job_type    slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in    = (push && !full) ? ~wr_ff : wr_ff;
      rd_in    = (pop && !empty) ? ~rd_ff : rd_ff;
      count_in = count_ff + 2'(push && !full) - 2'(pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && full) && !(pop && empty))
      else $error("job queue overrun or underrun");
`endif

endmodule

FILE: rtl/hvn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_back
// Normal unit: sums triangle normals, scales, normalizes the magnitudes and
// finds each rounded unit component by a 15-step digit search.
// ----------------------------------------------------------------------------
module hvn_back
   import hvn_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_pop,
   input  job_type                 job_data,
   input  logic [HGT_W-1:0]        height_scale,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [POS_W-1:0]        rsp_vertex_col,
   output logic [POS_W-1:0]        rsp_vertex_row,
   output logic signed [15:0]      rsp_normal_x,
   output logic [14:0]             rsp_normal_y,
   output logic signed [15:0]      rsp_normal_z,
   output logic                    rsp_last_of_run,
   output logic                    rsp_grid_done
);

   localparam int SW = 20;
   localparam int MW = 35;
   localparam int RW = 67;
   localparam logic [3:0] B_IDLE = 4'd0;
   localparam logic [3:0] B_SUM  = 4'd1;
   localparam logic [3:0] B_MULX = 4'd2;
   localparam logic [3:0] B_MULZ = 4'd3;
   localparam logic [3:0] B_NORM = 4'd4;
   localparam logic [3:0] B_SQ0  = 4'd5;
   localparam logic [3:0] B_SQ1  = 4'd6;
   localparam logic [3:0] B_SQ2  = 4'd7;
   localparam logic [3:0] B_ROOT = 4'd8;
   localparam logic [3:0] B_OUT  = 4'd9;

   logic [3:0]           state_ff, state_in;
   job_type              job_ff;
   logic signed [SW-1:0] sx_ff, sz_ff, sx_in, sz_in, mul_in;
   logic [2:0]           n_ff, n_in;
   logic signed [36:0]   prod;
   logic [36:0]          prod_mag;
   logic                 neg_x_ff, neg_z_ff;
   logic [MW-1:0]        mag_ff [3];
   logic [MW-1:0]        mag_or;
   logic [14:0]          sq_in;
   logic [29:0]          sq_out;
   logic [29:0]          sq_ff [3];
   logic [31:0]          s_ff, s_in;
   logic signed [RW-1:0] p_ff [3];
   logic signed [RW-1:0] a_ff [3];
   logic signed [RW-1:0] b_ff;
   logic signed [RW-1:0] pc [3];
   logic signed [RW-1:0] t_val [3];
   logic [2:0]           ok;
   logic [14:0]          lo_ff [3];
   logic [3:0]           k_ff;
   logic                 out_valid_ff, load;
   logic [15:0]          qx16, qz16;

   function automatic logic signed [SW-1:0] diff(input logic [HGT_W-1:0] a,
                                                 input logic [HGT_W-1:0] b);
      diff = $signed({4'b0000, a}) - $signed({4'b0000, b});
   endfunction

   always_comb begin
      sx_in = '0;
      sz_in = '0;
      n_in  = '0;
      if (job_ff.right && job_ff.down) begin
         sx_in = sx_in + diff(job_ff.hc, job_ff.hr);
         sz_in = sz_in + diff(job_ff.hc, job_ff.hd);
         n_in  = n_in + 3'd1;
      end
      if (job_ff.left && job_ff.down) begin
         sx_in = sx_in + diff(job_ff.hl, job_ff.hc) + diff(job_ff.hdl, job_ff.hd);
         sz_in = sz_in + diff(job_ff.hl, job_ff.hdl) + diff(job_ff.hc, job_ff.hd);
         n_in  = n_in + 3'd2;
      end
      if (job_ff.right && job_ff.up) begin
         sx_in = sx_in + diff(job_ff.hu, job_ff.hur) + diff(job_ff.hc, job_ff.hr);
         sz_in = sz_in + diff(job_ff.hu, job_ff.hc) + diff(job_ff.hur, job_ff.hr);
         n_in  = n_in + 3'd2;
      end
      if (job_ff.left && job_ff.up) begin
         sx_in = sx_in + diff(job_ff.hl, job_ff.hc);
         sz_in = sz_in + diff(job_ff.hu, job_ff.hc);
         n_in  = n_in + 3'd1;
      end
   end

   assign mul_in   = (state_ff == B_MULX) ? sx_ff : sz_ff;
   assign prod     = mul_in * $signed({1'b0, height_scale});
   assign prod_mag = prod[36] ? 37'(-prod) : prod;
   assign mag_or   = mag_ff[0] | mag_ff[1] | mag_ff[2];

   always_comb begin
      unique case (state_ff)
         B_SQ0:   sq_in = mag_ff[0][14:0];
         B_SQ1:   sq_in = mag_ff[1][14:0];
         default: sq_in = mag_ff[2][14:0];
      endcase
      sq_out = sq_in * sq_in;
      s_in   = s_ff + {2'b00, sq_out};
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t_val[i] = $signed({7'b0, sq_ff[i], 30'b0});
         pc[i]    = p_ff[i] + a_ff[i] + b_ff;
         ok[i]    = (pc[i] <= t_val[i]);
      end
   end

   assign job_pop   = (state_ff == B_IDLE) && job_valid;
   assign load      = (state_ff == B_OUT) && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;
   assign qx16      = (s_ff == '0) ? 16'd0 : {1'b0, lo_ff[0]};
   assign qz16      = (s_ff == '0) ? 16'd0 : {1'b0, lo_ff[2]};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (job_valid) begin
            state_in = B_SUM;
         end
         B_SUM:  state_in = B_MULX;
         B_MULX: state_in = B_MULZ;
         B_MULZ: state_in = B_NORM;
         B_NORM: if (mag_or[MW-1:15] == '0) begin
            state_in = B_SQ0;
         end
         B_SQ0:  state_in = B_SQ1;
         B_SQ1:  state_in = B_SQ2;
         B_SQ2:  state_in = B_ROOT;
         B_ROOT: if (k_ff == 4'd0) begin
            state_in = B_OUT;
         end
         B_OUT:  if (load) begin
            state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               job_ff <= job_data;
            end
         end
         B_SUM: begin
            sx_ff <= sx_in;
            sz_ff <= sz_in;
            n_ff  <= n_in;
         end
         B_MULX: begin
            neg_x_ff  <= prod[36];
            mag_ff[0] <= prod_mag[MW-1:0];
         end
         B_MULZ: begin
            neg_z_ff  <= prod[36];
            mag_ff[2] <= prod_mag[MW-1:0];
            mag_ff[1] <= {8'b0, n_ff, 24'b0};
         end
         B_NORM: begin
            for (int i = 0; i < 3; i++) begin
               if (mag_or[MW-1:19] != '0) begin
                  mag_ff[i] <= mag_ff[i] >> 4;
               end else if (mag_or[MW-1:15] != '0) begin
                  mag_ff[i] <= mag_ff[i] >> 1;
               end
            end
         end
         B_SQ0: begin
            sq_ff[0] <= sq_out;
            s_ff     <= {2'b00, sq_out};
         end
         B_SQ1: begin
            sq_ff[1] <= sq_out;
            s_ff     <= s_in;
         end
         B_SQ2: begin
            sq_ff[2] <= sq_out;
            s_ff     <= s_in;
            b_ff     <= $signed({5'b0, s_in, 30'b0});
            k_ff     <= 4'd14;
            for (int i = 0; i < 3; i++) begin
               p_ff[i]  <= $signed({35'b0, s_in});
               a_ff[i]  <= -$signed({19'b0, s_in, 16'b0});
               lo_ff[i] <= '0;
            end
         end
         B_ROOT: begin
            k_ff <= k_ff - 4'd1;
            b_ff <= b_ff >>> 2;
            for (int i = 0; i < 3; i++) begin
               if (ok[i]) begin
                  p_ff[i]  <= pc[i];
                  a_ff[i]  <= (a_ff[i] + (b_ff <<< 1)) >>> 1;
                  lo_ff[i] <= lo_ff[i] | (15'd1 << k_ff);
               end else begin
                  a_ff[i]  <= a_ff[i] >>> 1;
               end
            end
         end
         B_OUT: begin
            if (load) begin
               rsp_vertex_col  <= job_ff.vc;
               rsp_vertex_row  <= job_ff.vr;
               rsp_normal_x    <= neg_x_ff ? 16'(~qx16 + 16'd1) : qx16;
               rsp_normal_y    <= (s_ff == '0) ? 15'd0 : lo_ff[1];
               rsp_normal_z    <= neg_z_ff ? 16'(~qz16 + 16'd1) : qz16;
               rsp_last_of_run <= job_ff.last;
               rsp_grid_done   <= job_ff.done;
            end
         end
         default: begin
         end
      endcase
   end

`ifndef SYNTHESIS
   a_norm_narrow: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_SQ0 |-> mag_or[MW-1:15] == '0)
      else $error("magnitudes not narrowed before squaring");
   a_digit_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_OUT |-> int'(lo_ff[0]) <= Q_ONE && int'(lo_ff[1]) <= Q_ONE &&
                            int'(lo_ff[2]) <= Q_ONE)
      else $error("unit component above one");
   a_up_positive: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_normal_y != 15'd0)
      else $error("up component of a normal is zero");
`endif

endmodule

FILE: rtl/heightmap_vertex_normals.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_vertex_normals
// Streaming unit normals of a heightfield grid from raster-order samples.
// ----------------------------------------------------------------------------
//  channel   | ports                               | transaction
//  ----------+-------------------------------------+---------------------------
//  sample in | req_push, req_full, req_*           | push && !full
//  normal out| rsp_pop, rsp_empty, rsp_*           | pop && !empty
//  registers | csr_valid, csr_ready, csr_index/... | valid && ready
//
//  The front takes a sample in steps (accept, line buffer read and window
//  shift, then each vertex job it issues, one at a time, into a two-entry
//  queue) and takes no new sample until the last of those jobs is queued.
//  The normal unit finishes one vertex before it takes the next, through the
//  one-bit or four-bit normalizing shift loop and the 15-step digit search.
//  Synchronous active-high reset; no clearing pass, the line buffer needs none.
//  A full queue stalls the front; an unread result stalls the normal unit.
// ----------------------------------------------------------------------------
module heightmap_vertex_normals
   import hvn_pkg::*;
#(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [HGT_W-1:0]   req_sample_height,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [POS_W-1:0]   rsp_vertex_col,
   output logic [POS_W-1:0]   rsp_vertex_row,
   output logic signed [15:0] rsp_normal_x,
   output logic [14:0]        rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic               rsp_last_of_run,
   output logic               rsp_grid_done,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam logic [CNT_W-1:0] COLS_RST = CNT_W'(MAX_COLUMNS < 1024 ? MAX_COLUMNS : 1024);
   localparam logic [CNT_W-1:0] ROWS_RST = CNT_W'(MAX_ROWS < 1024 ? MAX_ROWS : 1024);

   logic [HGT_W-1:0] scale_ff;
   logic [CNT_W-1:0] cols_ff, rows_ff, size_val, cols_sat, rows_sat;
   logic             pos_clear, job_push, job_full, job_valid, job_pop, q_empty;
   job_type          push_job, pop_job;

   assign csr_ready = 1'b1;
   assign size_val  = csr_wdata[CNT_W-1:0];
   assign cols_sat  = (size_val < CNT_W'(2)) ? CNT_W'(2) :
                      (int'(size_val) > MAX_COLUMNS) ? CNT_W'(MAX_COLUMNS) : size_val;
   assign rows_sat  = (size_val < CNT_W'(2)) ? CNT_W'(2) :
                      (int'(size_val) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : size_val;
   assign pos_clear = csr_valid && (csr_index == CSR_COLS || csr_index == CSR_ROWS);
   assign job_valid = !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= HGT_W'(256);
         cols_ff  <= COLS_RST;
         rows_ff  <= ROWS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SCALE: scale_ff <= csr_wdata;
            CSR_COLS:  cols_ff  <= cols_sat;
            CSR_ROWS:  rows_ff  <= rows_sat;
            default: begin
            end
         endcase
      end
   end

   hvn_front #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_sample_height (req_sample_height),
      .grid_columns      (cols_ff),
      .grid_rows         (rows_ff),
      .pos_clear         (pos_clear),
      .job_push          (job_push),
      .job_full          (job_full),
      .job_data          (push_job)
   );

   hvn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .full      (job_full),
      .push_data (push_job),
      .pop       (job_pop),
      .empty     (q_empty),
      .pop_data  (pop_job)
   );

   hvn_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (job_valid),
      .job_pop         (job_pop),
      .job_data        (pop_job),
      .height_scale    (scale_ff),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_vertex_col  (rsp_vertex_col),
      .rsp_vertex_row  (rsp_vertex_row),
      .rsp_normal_x    (rsp_normal_x),
      .rsp_normal_y    (rsp_normal_y),
      .rsp_normal_z    (rsp_normal_z),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_grid_done   (rsp_grid_done)
   );

endmodule

FILE: test/heightmap_vertex_normals_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_vertex_normals_test
// Streams heightfield grids of many sizes and scales into the block and
// checks every vertex normal against an in-bench fixed-point normal
// calculator, with random idling on both queue sides and one long stall.
// ----------------------------------------------------------------------------
module heightmap_vertex_normals_test;
   import hvn_pkg::*;

   typedef struct {
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic [15:0]      nx;
      logic [14:0]      ny;
      logic [15:0]      nz;
      logic             last;
      logic             done;
   } normal_type;

   typedef enum logic {ROW_CSR, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]   idx;
      logic [15:0]  val;
      bit           flat;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic [HGT_W-1:0]   req_sample_height;
   logic               rsp_empty;
   logic               rsp_pop;
   logic [POS_W-1:0]   rsp_vertex_col;
   logic [POS_W-1:0]   rsp_vertex_row;
   logic signed [15:0] rsp_normal_x;
   logic [14:0]        rsp_normal_y;
   logic signed [15:0] rsp_normal_z;
   logic               rsp_last_of_run;
   logic               rsp_grid_done;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [15:0]        csr_wdata;

   heightmap_vertex_normals dut (.*);

   // shadow state of the block
   int unsigned     cur_scale;
   int unsigned     cur_cols;
   int unsigned     cur_rows;
   logic [15:0]     line_older [1024];
   logic [15:0]     line_newer [1024];
   logic [15:0]     window [9];
   int unsigned     next_col;
   int unsigned     next_row;

   normal_type      pending_normals [$];
   normal_type      step_normals [4];
   int              step_count;
   int              errors;
   int              hold_req;
   bit              no_idle;
   int              items_sent;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic longint win_at(int r, int c);
      if (r < 0 || r > 2 || c < 0 || c > 2) return 0;
      return longint'(window[r*3+c]);
   endfunction

   function automatic int unsigned round_q(longint unsigned a, longint unsigned s);
      int unsigned lo, hi, mid;
      longint unsigned t, rhs;
      lo = 0;
      hi = 16384;
      rhs = (a * a) << 30;
      if (s == 0) return 0;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t = 2 * longint'(mid) - 1;
         if (t * t * s <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic normal_type vertex_normal(int unsigned vc, int unsigned vr,
                                                int orow, int ocol);
      longint c, l, r, u, d, ur, dl, sx, sz, n, xs, zs;
      longint unsigned ax, ay, az, m, s;
      bit left, up, right, down;
      int unsigned qx, qz;
      normal_type res;
      c  = win_at(orow, ocol);
      l  = win_at(orow, ocol - 1);
      r  = win_at(orow, ocol + 1);
      u  = win_at(orow - 1, ocol);
      d  = win_at(orow + 1, ocol);
      ur = win_at(orow - 1, ocol + 1);
      dl = win_at(orow + 1, ocol - 1);
      left = vc > 0;
      up = vr > 0;
      right = vc + 1 < cur_cols;
      down = vr + 1 < cur_rows;
      sx = 0; sz = 0; n = 0;
      if (right && down) begin sx += c - r; sz += c - d; n += 1; end
      if (left && down) begin
         sx += (l - c) + (dl - d); sz += (l - dl) + (c - d); n += 2;
      end
      if (right && up) begin
         sx += (u - ur) + (c - r); sz += (u - c) + (ur - r); n += 2;
      end
      if (left && up) begin sx += l - c; sz += u - c; n += 1; end
      xs = sx * longint'(cur_scale);
      zs = sz * longint'(cur_scale);
      ax = xs < 0 ? -xs : xs;
      az = zs < 0 ? -zs : zs;
      ay = longint'(n) << 24;
      m = ax;
      if (ay > m) m = ay;
      if (az > m) m = az;
      while (m >= 32768) begin
         ax >>= 1; ay >>= 1; az >>= 1; m >>= 1;
      end
      s = ax * ax + ay * ay + az * az;
      qx = round_q(ax, s);
      qz = round_q(az, s);
      res.col  = vc[POS_W-1:0];
      res.row  = vr[POS_W-1:0];
      res.nx   = xs < 0 ? 16'(65536 - qx) : 16'(qx);
      res.ny   = 15'(round_q(ay, s));
      res.nz   = zs < 0 ? 16'(65536 - qz) : 16'(qz);
      res.last = 1'b0;
      res.done = (vc + 1 == cur_cols && vr + 1 == cur_rows);
      return res;
   endfunction

   function automatic void predict_sample(logic [15:0] smp);
      int unsigned c, r;
      int unsigned vcs [4];
      int unsigned vrs [4];
      logic [15:0] ov, nv;
      c = next_col;
      r = next_row;
      if (c >= cur_cols || c >= 1024) c = 0;
      if (r >= cur_rows) r = 0;
      ov = line_older[c];
      nv = line_newer[c];
      for (int i = 0; i < 3; i++) begin
         window[i*3]   = window[i*3+1];
         window[i*3+1] = window[i*3+2];
      end
      window[2] = ov;
      window[5] = nv;
      window[8] = smp;
      line_older[c] = nv;
      line_newer[c] = smp;
      step_count = 0;
      if (c >= 1 && r >= 1) begin
         vcs[step_count] = c - 1; vrs[step_count] = r - 1; step_count++;
      end
      if (c + 1 == cur_cols && r >= 1) begin
         vcs[step_count] = c; vrs[step_count] = r - 1; step_count++;
      end
      if (r + 1 == cur_rows && c >= 1) begin
         vcs[step_count] = c - 1; vrs[step_count] = r; step_count++;
      end
      if (r + 1 == cur_rows && c + 1 == cur_cols) begin
         vcs[step_count] = c; vrs[step_count] = r; step_count++;
      end
      for (int i = 0; i < step_count; i++) begin
         step_normals[i] = vertex_normal(vcs[i], vrs[i],
                                         int'(vrs[i]) - int'(r) + 2,
                                         int'(vcs[i]) - int'(c) + 2);
         if (i == step_count - 1) step_normals[i].last = 1'b1;
         pending_normals = {pending_normals, step_normals[i]};
      end
      if (c + 1 >= cur_cols) begin
         c = 0;
         r = (r + 1 >= cur_rows) ? 0 : r + 1;
      end else begin
         c++;
      end
      next_col = c;
      next_row = r;
   endfunction

   function automatic void apply_csr(logic [1:0] idx, logic [15:0] val);
      int unsigned v;
      v = val[10:0];
      if (idx == CSR_SCALE) begin
         cur_scale = val;
      end else if (idx == CSR_COLS || idx == CSR_ROWS) begin
         if (v < 2) v = 2;
         if (v > 1024) v = 1024;
         if (idx == CSR_COLS) cur_cols = v;
         else cur_rows = v;
         next_col = 0;
         next_row = 0;
      end
   endfunction

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 6);
   endfunction

   // called and returning at a falling edge
   task automatic push_sample(logic [15:0] h);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push = 1'b1;
      req_sample_height = h;
      do @(posedge clock); while (req_full);
      predict_sample(h);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_push = 1'b0;
      while (pending_normals.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      drain();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [15:0] draw_height(int mode, logic [15:0] base);
      case (mode)
         0: return 16'($urandom);
         1: return base + 16'($urandom_range(0, 255));
         default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      endcase
   endfunction

   // result side
   initial begin
      int gap;
      normal_type e;
      rsp_pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap();
         if (hold_req > 0) begin
            gap = hold_req;
            hold_req = 0;
         end
         if (gap > 0) begin
            rsp_pop = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop = 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (pending_normals.size() == 0) begin
            report($sformatf("unexpected normal at (%0d,%0d)",
                             rsp_vertex_col, rsp_vertex_row));
         end else begin
            e = pending_normals.pop_front();
            if (rsp_vertex_col !== e.col)
               report($sformatf("vertex_col %0d, want %0d", rsp_vertex_col, e.col));
            if (rsp_vertex_row !== e.row)
               report($sformatf("vertex_row %0d, want %0d", rsp_vertex_row, e.row));
            if (rsp_normal_x !== e.nx)
               report($sformatf("normal_x %0d, want %0d at (%0d,%0d)",
                                rsp_normal_x, $signed(e.nx), e.col, e.row));
            if (rsp_normal_y !== e.ny)
               report($sformatf("normal_y %0d, want %0d at (%0d,%0d)",
                                rsp_normal_y, e.ny, e.col, e.row));
            if (rsp_normal_z !== e.nz)
               report($sformatf("normal_z %0d, want %0d at (%0d,%0d)",
                                rsp_normal_z, $signed(e.nz), e.col, e.row));
            if (rsp_last_of_run !== e.last)
               report($sformatf("last_of_run %b, want %b", rsp_last_of_run, e.last));
            if (rsp_grid_done !== e.done)
               report($sformatf("grid_done %b, want %b", rsp_grid_done, e.done));
         end
         @(negedge clock);
      end
   end

   initial begin
      #30ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      stim_row_type plan [$];
      int cols, rows, count, mode, phase;
      logic [15:0] base, sc;

      reset = 1'b1;
      req_push = 1'b0;
      req_sample_height = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SCALE;
      csr_wdata = '0;
      errors = 0;
      hold_req = 0;
      no_idle = 1'b0;
      items_sent = 0;
      cur_scale = 256;
      cur_cols = 1024;
      cur_rows = 1024;
      next_col = 0;
      next_row = 0;
      foreach (window[i]) window[i] = '0;
      foreach (line_older[i]) begin
         line_older[i] = '0;
         line_newer[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      plan = '{
         '{ROW_CSR, CSR_COLS, 16'd2, 0}, '{ROW_CSR, CSR_ROWS, 16'd2, 0},
         '{ROW_CSR, CSR_SCALE, 16'd0, 0},
         '{ROW_SAMPLE, CSR_SCALE, 16'h0000, 1}, '{ROW_SAMPLE, CSR_SCALE, 16'hFFFF, 1},
         '{ROW_SAMPLE, CSR_SCALE, 16'hFFFF, 1}, '{ROW_SAMPLE, CSR_SCALE, 16'h0000, 1},
         '{ROW_CSR, CSR_SCALE, 16'hFFFF, 0},
         '{ROW_SAMPLE, CSR_SCALE, 16'h0000, 0}, '{ROW_SAMPLE, CSR_SCALE, 16'hFFFF, 0},
         '{ROW_SAMPLE, CSR_SCALE, 16'hFFFF, 0}, '{ROW_SAMPLE, CSR_SCALE, 16'h0000, 0},
         '{ROW_CSR, CSR_SCALE, 16'd256, 0}, '{ROW_CSR, CSR_COLS, 16'd3, 0},
         '{ROW_SAMPLE, CSR_SCALE, 16'h1234, 1}, '{ROW_SAMPLE, CSR_SCALE, 16'h1234, 1},
         '{ROW_SAMPLE, CSR_SCALE, 16'h1234, 1}, '{ROW_SAMPLE, CSR_SCALE, 16'h1234, 1},
         '{ROW_SAMPLE, CSR_SCALE, 16'h1234, 1}, '{ROW_SAMPLE, CSR_SCALE, 16'h1234, 1},
         '{ROW_CSR, CSR_COLS, 16'd0, 0}, '{ROW_CSR, CSR_ROWS, 16'd0, 0},
         '{ROW_SAMPLE, CSR_SCALE, 16'hFFFF, 0}, '{ROW_SAMPLE, CSR_SCALE, 16'h0000, 0},
         '{ROW_SAMPLE, CSR_SCALE, 16'h0000, 0}, '{ROW_SAMPLE, CSR_SCALE, 16'hFFFF, 0}
      };
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            write_csr(plan[i].idx, plan[i].val);
         end else begin
            push_sample(plan[i].val);
            if (plan[i].flat)
               for (int k = 0; k < step_count; k++)
                  if (step_normals[k].nx !== 16'd0 || step_normals[k].ny !== 15'(Q_ONE)
                      || step_normals[k].nz !== 16'd0)
                     report($sformatf("flat normal predicted wrong at (%0d,%0d)",
                                      step_normals[k].col, step_normals[k].row));
         end
      end

      // scale change in the middle of a grid
      write_csr(CSR_COLS, 16'd3);
      write_csr(CSR_ROWS, 16'd3);
      for (int i = 0; i < 4; i++) push_sample(16'($urandom));
      write_csr(CSR_SCALE, 16'd1000);
      for (int i = 0; i < 5; i++) push_sample(16'($urandom));

      phase = 0;
      while (items_sent < 150) begin
         cols = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 8);
         rows = $urandom_range(2, 5);
         case ($urandom_range(0, 4))
            0: sc = 16'd0;
            1: sc = 16'hFFFF;
            2: sc = 16'd256;
            default: sc = 16'($urandom);
         endcase
         write_csr(CSR_SCALE, sc);
         if ($urandom_range(0, 1)) begin
            write_csr(CSR_COLS, 16'(cols));
            write_csr(CSR_ROWS, 16'(rows));
         end else begin
            write_csr(CSR_ROWS, 16'(rows));
            write_csr(CSR_COLS, 16'(cols));
         end
         count = cols * rows * $urandom_range(1, 2);
         if ($urandom_range(0, 3) == 0) count = $urandom_range(1, cols * rows - 1);
         if (count > 40) count = 40;
         if (count > 160 - items_sent) count = 160 - items_sent;
         mode = $urandom_range(0, 2);
         base = 16'($urandom);
         no_idle = ($urandom_range(0, 3) == 0);
         if (phase == 2) begin
            no_idle = 1'b1;
            hold_req = 400;
         end
         for (int i = 0; i < count; i++) push_sample(draw_height(mode, base));
         phase++;
      end
      no_idle = 1'b0;

      // widest grid, column count saturating from above; first row only
      write_csr(CSR_SCALE, 16'($urandom));
      write_csr(CSR_COLS, 16'd2047);
      write_csr(CSR_ROWS, 16'd2);
      base = 16'($urandom);
      for (int i = 0; i < 30; i++) push_sample(draw_height(1, base));

      // tallest grid, row count saturating from above; a few rows only
      write_csr(CSR_COLS, 16'd2);
      write_csr(CSR_ROWS, 16'd2047);
      for (int i = 0; i < 40; i++) push_sample(16'($urandom));

      drain();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
